// ===== src/glzw_pkg.sv =====
// Shared types, constants and helpers for the GIF LZW stream decoder.
// Used by glzw_unpack and gif_lzw_stream_decoder; depends on nothing else.
package glzw_pkg;

  // String table and expansion stack geometry.
  localparam int unsigned TableEntries = 4096;
  localparam int unsigned TabAw = $clog2(TableEntries);
  localparam int unsigned StkAw = 12;
  localparam int unsigned LevelW = StkAw + 1;
  localparam int unsigned ResultsPerItem = 64;
  localparam int unsigned ObAw = $clog2(ResultsPerItem);
  localparam int unsigned NW = ObAw + 1;
  localparam logic [23:0] CountMax = 24'hFFFFFF;

  // Decoder phase, sticky once it leaves running.
  typedef enum logic [1:0] {
    PH_RUN      = 2'd0,
    PH_DONE     = 2'd1,
    PH_BAD      = 2'd2,
    PH_MISMATCH = 2'd3
  } phase_e;

  // Status code reported for a byte dropped while work is pending.
  localparam logic [2:0] StatusReject = 3'd4;

  // Configuration register indexes.
  localparam logic CfgMinCodeSize = 1'b0;
  localparam logic CfgImagePixels = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENG,
    ST_WALK,
    ST_ROOT,
    ST_OUT_RD,
    ST_OUT_SH
  } state_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       pixel_valid;
    logic [2:0] status;
    logic       more_pending;
    logic       last;
  } out_t;

  // Control word from the sequencer to the bit unpacker.
  typedef struct packed {
    logic load;
    logic take;
  } unpack_ctrl_t;

  // Clamp the minimum code size to the legal range of two to eight.
  function automatic logic [3:0] eff_size(input logic [3:0] mcs);
    logic [3:0] r;
    if (mcs < 4'd2) begin
      r = 4'd2;
    end else if (mcs > 4'd8) begin
      r = 4'd8;
    end else begin
      r = mcs;
    end
    return r;
  endfunction

  // Low-order mask of cw bits, cw up to 12.
  function automatic logic [12:0] width_mask(input logic [3:0] cw);
    return (13'd1 << cw) - 13'd1;
  endfunction

endpackage

// ===== src/glzw_unpack.sv =====
// Bit unpacker: gathers stream bytes LSB first and splits off variable-width codes.
// Depends on glzw_pkg.
module glzw_unpack (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  glzw_pkg::unpack_ctrl_t ctrl_i,
  input  logic [7:0]            byte_i,
  input  logic [3:0]            width_i,
  output logic [11:0]           code_o,
  output logic [4:0]            count_o
);

  logic [19:0] buf_q, buf_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [12:0] mask;
  logic [27:0] ins;

  assign mask = glzw_pkg::width_mask(width_i);
  assign ins  = 28'(byte_i) << cnt_q;

  // Current code is the low bits of the buffer.
  assign code_o  = buf_q[11:0] & mask[11:0];
  assign count_o = cnt_q;

  // Append a byte above the held bits, or consume one code.
  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      buf_d = buf_q | ins[19:0];
      cnt_d = cnt_q + 5'd8;
    end else if (ctrl_i.take) begin
      buf_d = buf_q >> width_i;
      cnt_d = cnt_q - 5'(width_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      cnt_q <= '0;
    end else begin
      buf_q <= buf_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== src/gif_lzw_stream_decoder.sv =====
// GIF LZW image-data decoder: string table, expansion stack, result buffer, control.
// Depends on glzw_pkg and glzw_unpack.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o   | in_data_i  (mode, data_byte)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (pixel ... last)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item at a time. The engine pops pixels from the stack, walks string table
// entries (the table read is registered) and decodes codes; results then leave
// one word at a time. Reset clears control only; the table and stack memories
// hold whatever was written. A stalled output holds the sequencer in its emit
// state; configuration is always accepted.
module gif_lzw_stream_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  glzw_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output glzw_pkg::out_t   out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [23:0]      cfg_data_i
);

  glzw_pkg::state_e state_q, state_d;
  glzw_pkg::phase_e phase_q, phase_d;

  logic                       rejected_q, rejected_d;
  logic [glzw_pkg::NW-1:0]    n_q, n_d;
  logic [glzw_pkg::ObAw-1:0]  k_q, k_d;
  logic [3:0]                 mcs_q, mcs_d;
  logic [23:0]                img_q, img_d;
  logic [glzw_pkg::LevelW-1:0] level_q, level_d;
  logic [12:0]                nfc_q, nfc_d;
  logic [11:0]                prev_q, prev_d;
  logic                       prev_valid_q, prev_valid_d;
  logic [7:0]                 prev_first_q, prev_first_d;
  logic [3:0]                 cw_q, cw_d;
  logic [7:0]                 bbl_q, bbl_d;
  logic [23:0]                pix_q, pix_d;
  logic                       over_q, over_d;
  logic [11:0]                code_q, code_d;
  logic                       kwk_q, kwk_d;
  logic [7:0]                 root_q, root_d;
  logic                       pop_pend_q;
  logic [glzw_pkg::ObAw-1:0]  wr_idx_q;
  logic                       out_valid_q;
  glzw_pkg::out_t             out_q, out_d;
  logic                       out_load;

  // Memories.
  logic [19:0] tab_mem [glzw_pkg::TableEntries];
  logic [19:0] tab_rdata_q, tab_wdata;
  logic [glzw_pkg::TabAw-1:0] tab_raddr, tab_waddr;
  logic        tab_re, tab_we;
  logic [7:0]  stk_mem [2**glzw_pkg::StkAw];
  logic [7:0]  stk_rdata_q, stk_wdata;
  logic        stk_we;
  logic [7:0]  ob_mem [glzw_pkg::ResultsPerItem];
  logic [7:0]  ob_rdata_q;

  // Unpacker.
  glzw_pkg::unpack_ctrl_t uctrl;
  logic [11:0] code;
  logic [4:0]  bit_cnt;

  glzw_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (uctrl),
    .byte_i  (in_data_i.data_byte),
    .width_i (cw_q),
    .code_o  (code),
    .count_o (bit_cnt)
  );

  // Shared decode terms.
  logic [3:0]  es;
  logic [12:0] clr13, lim13, code13, nf_inc, mask13;
  logic        have_code, pending, in_acc, running, n_full;
  logic        eng_pop, eng_dec, eng_stop;
  logic        is_clr, is_end, is_old, is_kwk, old_lit, prev_lit;
  logic        grow, tab_room, walk_more, root_add, last_res;
  logic [11:0] walk_prefix;

  assign es        = glzw_pkg::eff_size(mcs_q);
  assign clr13     = 13'd1 << es;
  assign lim13     = clr13 + 13'd2;
  assign code13    = {1'b0, code};
  assign mask13    = glzw_pkg::width_mask(cw_q);
  assign nf_inc    = nfc_q + 13'd1;
  assign grow      = ((nf_inc & mask13) == 13'd0) && (nf_inc < 13'(glzw_pkg::TableEntries));
  assign tab_room  = nfc_q < 13'(glzw_pkg::TableEntries);
  assign have_code = bit_cnt >= {1'b0, cw_q};
  assign running   = phase_q == glzw_pkg::PH_RUN;
  assign pending   = running && ((level_q != '0) || have_code);
  assign in_acc    = in_valid_i && (state_q == glzw_pkg::ST_IDLE);
  assign n_full    = n_q == glzw_pkg::NW'(glzw_pkg::ResultsPerItem);

  assign eng_pop  = (state_q == glzw_pkg::ST_ENG) && running && !n_full && (level_q != '0);
  assign eng_dec  = (state_q == glzw_pkg::ST_ENG) && running && !n_full && (level_q == '0)
                    && have_code;
  assign eng_stop = (state_q == glzw_pkg::ST_ENG) && !eng_pop && !eng_dec;

  assign is_clr   = code13 == clr13;
  assign is_end   = code13 == clr13 + 13'd1;
  assign is_old   = !is_clr && !is_end && (code13 < nfc_q);
  assign is_kwk   = !is_clr && !is_end && (code13 == nfc_q) && prev_valid_q && tab_room;
  assign old_lit  = code13 < lim13;
  assign prev_lit = {1'b0, prev_q} < lim13;

  assign walk_prefix = tab_rdata_q[19:8];
  assign walk_more   = {1'b0, walk_prefix} >= lim13;
  assign root_add    = (state_q == glzw_pkg::ST_ROOT) && !kwk_q && prev_valid_q && tab_room;

  assign last_res = (n_q == '0) || ({1'b0, k_q} == n_q - glzw_pkg::NW'(1));
  assign out_load = (state_q == glzw_pkg::ST_OUT_SH) && (!out_valid_q || out_ready_i);

  assign uctrl.load = in_acc && running && !in_data_i.mode && !pending && (bbl_q != '0);
  assign uctrl.take = eng_dec;

  // Table port selection.
  always_comb begin
    tab_re    = 1'b0;
    tab_raddr = code;
    if (eng_dec && is_old && !old_lit) begin
      tab_re = 1'b1;
    end else if (eng_dec && is_kwk && !prev_lit) begin
      tab_re    = 1'b1;
      tab_raddr = prev_q;
    end else if ((state_q == glzw_pkg::ST_WALK) && walk_more) begin
      tab_re    = 1'b1;
      tab_raddr = walk_prefix;
    end
    tab_we    = (eng_dec && is_kwk) || root_add;
    tab_waddr = nfc_q[glzw_pkg::TabAw-1:0];
    tab_wdata = (state_q == glzw_pkg::ST_ROOT) ? {prev_q, root_q} : {prev_q, prev_first_q};
  end

  // Stack push selection.
  always_comb begin
    stk_we    = (eng_dec && is_kwk) || (state_q == glzw_pkg::ST_WALK)
                || (state_q == glzw_pkg::ST_ROOT);
    stk_wdata = prev_first_q;
    if (state_q == glzw_pkg::ST_WALK) begin
      stk_wdata = tab_rdata_q[7:0];
    end else if (state_q == glzw_pkg::ST_ROOT) begin
      stk_wdata = root_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    if (tab_re) begin
      tab_rdata_q <= tab_mem[tab_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[level_q[glzw_pkg::StkAw-1:0]] <= stk_wdata;
    end
    if (eng_pop) begin
      stk_rdata_q <= stk_mem[level_q[glzw_pkg::StkAw-1:0] - glzw_pkg::StkAw'(1)];
    end
  end

  // Result buffer: popped pixels land in the cycle after the stack read.
  always_ff @(posedge clk_i) begin
    if (pop_pend_q) begin
      ob_mem[wr_idx_q] <= stk_rdata_q;
    end
    if (state_q == glzw_pkg::ST_OUT_RD) begin
      ob_rdata_q <= ob_mem[k_q];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      glzw_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (running && (in_data_i.mode || (!pending && (bbl_q != '0)))) begin
            state_d = glzw_pkg::ST_ENG;
          end else begin
            state_d = glzw_pkg::ST_OUT_SH;
          end
        end
      end
      glzw_pkg::ST_ENG: begin
        if (eng_dec && is_old) begin
          state_d = old_lit ? glzw_pkg::ST_ROOT : glzw_pkg::ST_WALK;
        end else if (eng_dec && is_kwk) begin
          state_d = prev_lit ? glzw_pkg::ST_ROOT : glzw_pkg::ST_WALK;
        end else if (eng_stop) begin
          state_d = (n_q == '0) ? glzw_pkg::ST_OUT_SH : glzw_pkg::ST_OUT_RD;
        end
      end
      glzw_pkg::ST_WALK: begin
        if (!walk_more) begin
          state_d = glzw_pkg::ST_ROOT;
        end
      end
      glzw_pkg::ST_ROOT:   state_d = glzw_pkg::ST_ENG;
      glzw_pkg::ST_OUT_RD: state_d = glzw_pkg::ST_OUT_SH;
      glzw_pkg::ST_OUT_SH: begin
        if (out_load) begin
          state_d = last_res ? glzw_pkg::ST_IDLE : glzw_pkg::ST_OUT_RD;
        end
      end
      default: state_d = glzw_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    phase_d      = phase_q;
    rejected_d   = rejected_q;
    n_d          = n_q;
    k_d          = k_q;
    mcs_d        = mcs_q;
    img_d        = img_q;
    level_d      = level_q;
    nfc_d        = nfc_q;
    prev_d       = prev_q;
    prev_valid_d = prev_valid_q;
    prev_first_d = prev_first_q;
    cw_d         = cw_q;
    bbl_d        = bbl_q;
    pix_d        = pix_q;
    over_d       = over_q;
    code_d       = code_q;
    kwk_d        = kwk_q;
    root_d       = root_q;
    out_d        = out_q;

    // Item intake.
    if (in_acc) begin
      n_d        = '0;
      k_d        = '0;
      rejected_d = 1'b0;
      if (running && !in_data_i.mode) begin
        if (pending) begin
          rejected_d = 1'b1;
        end else if (bbl_q == '0) begin
          if (in_data_i.data_byte == '0) begin
            phase_d = (!over_q && (pix_q == img_q)) ? glzw_pkg::PH_DONE
                                                    : glzw_pkg::PH_MISMATCH;
          end else begin
            bbl_d = in_data_i.data_byte;
          end
        end else begin
          bbl_d = bbl_q - 8'd1;
        end
      end
    end

    // Pop one pixel toward the result buffer.
    if (eng_pop) begin
      level_d = level_q - glzw_pkg::LevelW'(1);
      n_d     = n_q + glzw_pkg::NW'(1);
      if (pix_q >= glzw_pkg::CountMax) begin
        over_d = 1'b1;
      end else begin
        pix_d = pix_q + 24'd1;
      end
    end

    // Decode one code.
    if (eng_dec) begin
      code_d = code;
      if (is_clr) begin
        cw_d         = es + 4'd1;
        nfc_d        = lim13;
        prev_valid_d = 1'b0;
      end else if (is_end) begin
        phase_d = (!over_q && (pix_q == img_q)) ? glzw_pkg::PH_DONE : glzw_pkg::PH_MISMATCH;
      end else if (is_old) begin
        kwk_d  = 1'b0;
        root_d = code[7:0];
      end else if (is_kwk) begin
        // New entry repeats the previous string plus its own first byte.
        kwk_d   = 1'b1;
        root_d  = prev_q[7:0];
        nfc_d   = nf_inc;
        level_d = level_q + glzw_pkg::LevelW'(1);
        if (grow) begin
          cw_d = cw_q + 4'd1;
        end
      end else begin
        phase_d = glzw_pkg::PH_BAD;
      end
    end

    // Walk one table entry per cycle.
    if (state_q == glzw_pkg::ST_WALK) begin
      level_d = level_q + glzw_pkg::LevelW'(1);
      root_d  = walk_prefix[7:0];
    end

    // Push the first byte and record the code.
    if (state_q == glzw_pkg::ST_ROOT) begin
      level_d = level_q + glzw_pkg::LevelW'(1);
      prev_d  = code_q;
      if (!kwk_q) begin
        prev_first_d = root_q;
        prev_valid_d = 1'b1;
      end
      if (root_add) begin
        nfc_d = nf_inc;
        if (grow) begin
          cw_d = cw_q + 4'd1;
        end
      end
    end

    // Emit one result word.
    if (out_load) begin
      k_d                = k_q + glzw_pkg::ObAw'(1);
      out_d.pixel        = (n_q == '0) ? 8'd0 : ob_rdata_q;
      out_d.pixel_valid  = n_q != '0;
      out_d.status       = rejected_q ? glzw_pkg::StatusReject : {1'b0, phase_q};
      out_d.more_pending = pending;
      out_d.last         = last_res;
    end

    // Configuration writes.
    if (cfg_valid_i) begin
      if (cfg_index_i == glzw_pkg::CfgMinCodeSize) begin
        mcs_d        = cfg_data_i[3:0];
        cw_d         = glzw_pkg::eff_size(cfg_data_i[3:0]) + 4'd1;
        nfc_d        = (13'd1 << glzw_pkg::eff_size(cfg_data_i[3:0])) + 13'd2;
        prev_valid_d = 1'b0;
      end else begin
        img_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= glzw_pkg::ST_IDLE;
      phase_q      <= glzw_pkg::PH_RUN;
      rejected_q   <= 1'b0;
      n_q          <= '0;
      k_q          <= '0;
      mcs_q        <= 4'd8;
      img_q        <= '0;
      level_q      <= '0;
      nfc_q        <= 13'd258;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      prev_first_q <= '0;
      cw_q         <= 4'd9;
      bbl_q        <= '0;
      pix_q        <= '0;
      over_q       <= 1'b0;
      kwk_q        <= 1'b0;
      pop_pend_q   <= 1'b0;
      wr_idx_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      rejected_q   <= rejected_d;
      n_q          <= n_d;
      k_q          <= k_d;
      mcs_q        <= mcs_d;
      img_q        <= img_d;
      level_q      <= level_d;
      nfc_q        <= nfc_d;
      prev_q       <= prev_d;
      prev_valid_q <= prev_valid_d;
      prev_first_q <= prev_first_d;
      cw_q         <= cw_d;
      bbl_q        <= bbl_d;
      pix_q        <= pix_d;
      over_q       <= over_d;
      kwk_q        <= kwk_d;
      pop_pend_q   <= eng_pop;
      wr_idx_q     <= n_q[glzw_pkg::ObAw-1:0];
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    root_q <= root_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = state_q == glzw_pkg::ST_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // The result count never passes the per-item limit.
  a_n_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= glzw_pkg::NW'(glzw_pkg::ResultsPerItem))
    else $error("result count above limit");

  // A pending buffer write always follows a pop issued by the engine.
  a_pop_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_pend_q |-> $past(state_q == glzw_pkg::ST_ENG))
    else $error("buffer write without a pop");

  // A finished phase is sticky.
  a_phase_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != glzw_pkg::PH_RUN) |=> (phase_q == $past(phase_q)))
    else $error("finished phase changed");

  // The stack stays within its depth.
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= glzw_pkg::LevelW'(2**glzw_pkg::StkAw))
    else $error("stack overflow");
`endif

endmodule
